[sv/srgbl_pkg.sv]
`default_nettype none
package srgbl_pkg;

	// stream payload widths
	localparam int unsigned CHAN_W  = 8;
	localparam int unsigned LIN_W   = 16;
	localparam int unsigned XYZ_W   = 33;
	localparam int unsigned INV_W   = 17;
	localparam int unsigned THR_W   = 16;
	localparam int unsigned RATIO_W = 18;
	localparam int unsigned CBRT_W  = 17;
	localparam int unsigned F_W     = 20;
	localparam int unsigned L_W     = 14;
	localparam int unsigned AB_W    = 15;
	localparam int unsigned CFG_IDX_W = 2;
	localparam int unsigned CFG_DATA_W = 17;

	localparam int unsigned CBRT_TABLE_DEPTH_DEF = 1024;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] REG_INV_WHITE_X = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_INV_WHITE_Y = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_INV_WHITE_Z = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_LIN_THRESH  = 2'd3;

	localparam logic [INV_W-1:0] INV_WHITE_X_RST = 17'd68953;
	localparam logic [INV_W-1:0] INV_WHITE_Y_RST = 17'd65536;
	localparam logic [INV_W-1:0] INV_WHITE_Z_RST = 17'd60189;
	localparam logic [THR_W-1:0] LIN_THRESH_RST  = 16'd580;

	// linear segment: slope 7.787 in Q16, offset 16/116 in Q16
	localparam logic [18:0] LIN_SLOPE  = 19'd510329;
	localparam logic [F_W-1:0] LIN_OFFSET = 20'd9039;

	typedef logic [LIN_W-1:0] gamma_rom_t [256];

	// one entry of the sRGB decode curve, Q0.16
	function automatic logic [LIN_W-1:0] gamma_entry(input int unsigned code);
		longint unsigned i, y, p, s, w, lo, hi, mid, sq, m4;
		i = longint'(code);
		if (i * 100000 <= 64'd4045 * 64'd255) begin
			y = (i * 64'd6553600 + 64'd164730) / 64'd329460;
		end else begin
			p = 64'd1000 * i + 64'd14025;
			s = (p << 32) / 64'd269025;
			if (s > 64'hFFFF_FFFF) s = 64'hFFFF_FFFF;
			w = (s * s) >> 32;
			// fifth root by bisection
			lo = 0;
			hi = 65535;
			while (lo < hi) begin
				mid = (lo + hi + 1) / 2;
				sq = mid * mid;
				m4 = sq * sq;
				if ((m4 >> 16) * mid <= (w << 32)) lo = mid;
				else hi = mid - 1;
			end
			y = (w * lo + 64'h8000_0000) >> 32;
		end
		if (y > 65535) y = 65535;
		return y[LIN_W-1:0];
	endfunction

	function automatic gamma_rom_t build_gamma();
		gamma_rom_t rom;
		for (int unsigned k = 0; k < 256; k++) rom[k] = gamma_entry(k);
		return rom;
	endfunction

	localparam gamma_rom_t GAMMA_ROM = build_gamma();

	// largest r with r^3 <= target
	function automatic logic [CBRT_W-1:0] cube_root_floor(input longint unsigned target);
		longint unsigned lo, hi, mid;
		lo = 0;
		hi = 131072;
		while (lo < hi) begin
			mid = (lo + hi + 1) / 2;
			if (mid * mid * mid <= target) lo = mid;
			else hi = mid - 1;
		end
		return lo[CBRT_W-1:0];
	endfunction

endpackage
`default_nettype wire

[sv/srgbl_labf.sv]
`default_nettype none
module srgbl_labf #(
	parameter int unsigned CBRT_TABLE_DEPTH = srgbl_pkg::CBRT_TABLE_DEPTH_DEF
) (
	input  wire logic                          clk,
	input  wire logic                          en,
	input  wire logic [srgbl_pkg::XYZ_W-1:0]   xyz_s3,
	input  wire logic [srgbl_pkg::INV_W-1:0]   inv_white,
	input  wire logic [srgbl_pkg::THR_W-1:0]   threshold,
	output logic      [srgbl_pkg::F_W-1:0]     f_s8
);
	import srgbl_pkg::*;

	localparam int unsigned IW = $clog2(CBRT_TABLE_DEPTH + 1);
	localparam int unsigned PW = RATIO_W + IW;
	localparam int unsigned PROD_W = XYZ_W + INV_W;

	// cube root table, Q1.16, covering ratio 0..4
	logic [CBRT_W-1:0] cbrt_rom [CBRT_TABLE_DEPTH+1];
	for (genvar k = 0; k <= CBRT_TABLE_DEPTH; k++) begin : g_rom
		localparam longint unsigned TGT = (longint'(k) << 50) / CBRT_TABLE_DEPTH;
		assign cbrt_rom[k] = cube_root_floor(TGT);
	end

	logic [PROD_W-1:0]  prod_s4;
	logic [RATIO_W-1:0] t_s5;
	logic               cbrt_s5, cbrt_s6, cbrt_s7;
	logic [IW-1:0]      idx_s5;
	logic [RATIO_W-1:0] frac_s5, frac_s6;
	logic [CBRT_W-1:0]  e0_s6, e1_s6, e0_s7;
	logic [36:0]        lin_s6;
	logic [34:0]        dprod_s7;
	logic [F_W-1:0]     linf_s7;

	logic [PROD_W:0]    rnd;
	logic [PROD_W-32:0] tq;
	logic [RATIO_W-1:0] t_sat;
	logic [PW-1:0]      pos;
	logic [CBRT_W-1:0]  diff;
	logic [36:0]        lin_rnd;
	logic [34:0]        dp_rnd;

	// ratio: round, saturate, then table position
	always_comb begin
		rnd = {1'b0, prod_s4} + (PROD_W+1)'(64'h8000_0000);
		tq = rnd[PROD_W:32];
		t_sat = (tq > (PROD_W-31)'((1 << RATIO_W) - 1)) ? '1 : tq[RATIO_W-1:0];
		pos = PW'(t_sat) * PW'(CBRT_TABLE_DEPTH);
	end

	always_comb begin
		diff = (e1_s6 >= e0_s6) ? (e1_s6 - e0_s6) : '0;
		lin_rnd = lin_s6 + 37'd32768;
		dp_rnd = dprod_s7 + 35'd131072;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			// scale by white point reciprocal
			prod_s4 <= PROD_W'(xyz_s3) * PROD_W'(inv_white);
			// segment select and table address
			t_s5 <= t_sat;
			cbrt_s5 <= (t_sat > RATIO_W'(threshold));
			idx_s5 <= pos[PW-1:RATIO_W];
			frac_s5 <= pos[RATIO_W-1:0];
			// table reads and linear product
			e0_s6 <= cbrt_rom[idx_s5];
			e1_s6 <= cbrt_rom[idx_s5 + IW'(1)];
			lin_s6 <= 37'(t_s5) * 37'(LIN_SLOPE);
			frac_s6 <= frac_s5;
			cbrt_s6 <= cbrt_s5;
			// interpolation product
			dprod_s7 <= 35'(diff) * 35'(frac_s6);
			e0_s7 <= e0_s6;
			linf_s7 <= F_W'(lin_rnd[36:16]) + LIN_OFFSET;
			cbrt_s7 <= cbrt_s6;
			// segment result
			f_s8 <= cbrt_s7 ? (F_W'(e0_s7) + F_W'(dp_rnd[34:18])) : linf_s7;
		end
	end

endmodule
`default_nettype wire

[sv/srgb_to_cielab.sv]
`default_nettype none
// sRGB to CIELab converter. One 8-bit pixel per clock in, one Lab result per
// clock out while not stalled. The pipeline stages are, in order: gamma table,
// matrix products, matrix sums, white point scaling, ratio rounding, cube root
// table read, interpolation product, segment select, Lab arithmetic and output
// rounding. A stall on the output while a result is valid freezes the whole
// pipeline and is passed straight back to the input. Lightness, a* and b* are
// in units of 1/128, saturated. White point reciprocals and the linear segment
// threshold are written through the configuration port; the user must write
// them only while no pixel is in flight, which the block does not enforce.
module srgb_to_cielab #(
	parameter int unsigned CBRT_TABLE_DEPTH = srgbl_pkg::CBRT_TABLE_DEPTH_DEF
) (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                in_valid,
	output logic                                     in_stall,
	input  wire logic [srgbl_pkg::CHAN_W-1:0]        red,
	input  wire logic [srgbl_pkg::CHAN_W-1:0]        green,
	input  wire logic [srgbl_pkg::CHAN_W-1:0]        blue,
	output logic                                     out_valid,
	input  wire logic                                out_stall,
	output logic      [srgbl_pkg::L_W-1:0]           lightness,
	output logic signed [srgbl_pkg::AB_W-1:0]        green_red,
	output logic signed [srgbl_pkg::AB_W-1:0]        blue_yellow,
	input  wire logic                                cfg_we,
	input  wire logic [srgbl_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  wire logic [srgbl_pkg::CFG_DATA_W-1:0]    cfg_data
);
	import srgbl_pkg::*;

	localparam int unsigned NSTAGE = 10;

	logic [INV_W-1:0] inv_x_q, inv_y_q, inv_z_q;
	logic [THR_W-1:0] thr_q;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			inv_x_q <= INV_WHITE_X_RST;
			inv_y_q <= INV_WHITE_Y_RST;
			inv_z_q <= INV_WHITE_Z_RST;
			thr_q <= LIN_THRESH_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_INV_WHITE_X: inv_x_q <= cfg_data;
				REG_INV_WHITE_Y: inv_y_q <= cfg_data;
				REG_INV_WHITE_Z: inv_z_q <= cfg_data;
				REG_LIN_THRESH:  thr_q <= cfg_data[THR_W-1:0];
				default: ;
			endcase
		end
	end

	// pipeline advance
	logic en;
	logic [NSTAGE-1:0] valid_s;
	assign en = !(valid_s[NSTAGE-1] && out_stall);
	assign in_stall = !en;
	assign out_valid = valid_s[NSTAGE-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s <= '0;
		end else if (en) begin
			valid_s <= {valid_s[NSTAGE-2:0], in_valid};
		end
	end

	logic [LIN_W-1:0] lr_s1, lg_s1, lb_s1;
	logic [31:0] xr_s2, xg_s2, xb_s2, yr_s2, yg_s2, yb_s2, zr_s2, zg_s2, zb_s2;
	logic [XYZ_W-1:0] x_s3, y_s3, z_s3;
	logic [F_W-1:0] fx_s8, fy_s8, fz_s8;
	logic signed [27:0] l_s9;
	logic signed [30:0] a_s9, b_s9;

	// gamma decode and color matrix
	always_ff @(posedge clk) begin
		if (en) begin
			lr_s1 <= GAMMA_ROM[red];
			lg_s1 <= GAMMA_ROM[green];
			lb_s1 <= GAMMA_ROM[blue];
			xr_s2 <= 32'(lr_s1) * 32'd27027;
			xg_s2 <= 32'(lg_s1) * 32'd23436;
			xb_s2 <= 32'(lb_s1) * 32'd11829;
			yr_s2 <= 32'(lr_s1) * 32'd13933;
			yg_s2 <= 32'(lg_s1) * 32'd46871;
			yb_s2 <= 32'(lb_s1) * 32'd4732;
			zr_s2 <= 32'(lr_s1) * 32'd1265;
			zg_s2 <= 32'(lg_s1) * 32'd7812;
			zb_s2 <= 32'(lb_s1) * 32'd62292;
			x_s3 <= XYZ_W'(xr_s2) + XYZ_W'(xg_s2) + XYZ_W'(xb_s2);
			y_s3 <= XYZ_W'(yr_s2) + XYZ_W'(yg_s2) + XYZ_W'(yb_s2);
			z_s3 <= XYZ_W'(zr_s2) + XYZ_W'(zg_s2) + XYZ_W'(zb_s2);
		end
	end

	// per-axis ratio and f(t)
	srgbl_labf #(.CBRT_TABLE_DEPTH(CBRT_TABLE_DEPTH)) u_fx (
		.clk(clk), .en(en), .xyz_s3(x_s3), .inv_white(inv_x_q),
		.threshold(thr_q), .f_s8(fx_s8)
	);
	srgbl_labf #(.CBRT_TABLE_DEPTH(CBRT_TABLE_DEPTH)) u_fy (
		.clk(clk), .en(en), .xyz_s3(y_s3), .inv_white(inv_y_q),
		.threshold(thr_q), .f_s8(fy_s8)
	);
	srgbl_labf #(.CBRT_TABLE_DEPTH(CBRT_TABLE_DEPTH)) u_fz (
		.clk(clk), .en(en), .xyz_s3(z_s3), .inv_white(inv_z_q),
		.threshold(thr_q), .f_s8(fz_s8)
	);

	// divide by 512, rounding half away from zero
	function automatic logic signed [21:0] div512(input logic signed [30:0] v);
		logic [30:0] mag;
		logic [21:0] q;
		mag = v[30] ? 31'(-v) : 31'(v);
		q = 22'((mag + 31'd256) >> 9);
		return v[30] ? -signed'(q) : signed'(q);
	endfunction

	logic signed [21:0] l_div, a_div, b_div;
	always_comb begin
		l_div = div512(31'(l_s9));
		a_div = div512(a_s9);
		b_div = div512(b_s9);
	end

	// Lab arithmetic and saturation
	always_ff @(posedge clk) begin
		if (en) begin
			l_s9 <= 28'sd116 * signed'(28'(fy_s8)) - 28'sd1048576;
			a_s9 <= 31'sd500 * (signed'(31'(fx_s8)) - signed'(31'(fy_s8)));
			b_s9 <= 31'sd200 * (signed'(31'(fy_s8)) - signed'(31'(fz_s8)));
			if (l_div < 0) lightness <= '0;
			else if (l_div > 22'sd12800) lightness <= 14'd12800;
			else lightness <= l_div[L_W-1:0];
			if (a_div < -22'sd16384) green_red <= -15'sd16384;
			else if (a_div > 22'sd16383) green_red <= 15'sd16383;
			else green_red <= a_div[AB_W-1:0];
			if (b_div < -22'sd16384) blue_yellow <= -15'sd16384;
			else if (b_div > 22'sd16383) blue_yellow <= 15'sd16383;
			else blue_yellow <= b_div[AB_W-1:0];
		end
	end

endmodule
`default_nettype wire
